@@ hw/rtl/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

  // Screen geometry.
  localparam int COLUMNS         = 80;
  localparam int ROWS            = 25;
  localparam int CELL_COUNT      = ROWS * COLUMNS;
  localparam int LAST_LINE_START = (ROWS - 1) * COLUMNS;

  // Field and storage widths.
  localparam int CELL_W = 11;
  localparam int DATA_W = 16;
  localparam int CHAR_W = 8;
  localparam int CMD_W  = 2;
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ADDR_W = $clog2(CELL_COUNT);

  // Cell contents and control characters.
  localparam logic [DATA_W-1:0] TEXT_ATTR      = 16'h0F00;
  localparam logic [DATA_W-1:0] BLANK_CELL     = 16'h0F20;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

endpackage

`default_nettype wire

@@ hw/rtl/tcw_in_if.sv @@
`default_nettype none

interface tcw_in_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CHAR_W-1:0] char_code;
  logic [CELL_W-1:0] cell_index;

  modport source (output valid, output cmd, output char_code, output cell_index,
                  input ready);
  modport sink   (input valid, input cmd, input char_code, input cell_index,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tcw_out_if.sv @@
`default_nettype none

interface tcw_out_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cursor_pos;
  logic [DATA_W-1:0] cell_value;
  logic              scrolled;

  modport source (output valid, output cursor_pos, output cell_value, output scrolled,
                  input ready);
  modport sink   (input valid, input cursor_pos, input cell_value, input scrolled,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/text_console_writer.sv @@
// Put, backspace, newline, read and unused commands go from the input transfer
// to ST_DONE and then to the result register; no new item is taken before that.
// A scroll walks the screen memory: it copies the 1920 cells below the top row
// up one row, then blanks the 80 cells of the bottom row. A clear blanks all 2000 cells.
// Each pass goes through the single write port of the screen memory.
// After reset a clearing pass blanks all 2000 cells; input is not ready until it ends.
`default_nettype none

module text_console_writer (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcw_in_if.sink    in_i,
  tcw_out_if.source out_o
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_COPY,
    ST_BLANK,
    ST_SWEEP,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [CELL_W-1:0] cnt_q;
  logic              cp_valid_q;
  logic [CELL_W-1:0] cp_addr_q;
  logic [CELL_W-1:0] cursor_q;
  logic [CELL_W-1:0] line_q;
  logic [COL_W-1:0]  col_q;
  logic              scrolled_q;
  logic              rd_hit_q;
  logic              out_valid_q;
  logic [CELL_W-1:0] out_cursor_q;
  logic [DATA_W-1:0] out_value_q;
  logic              out_scrolled_q;

  logic              in_fire;
  logic              is_bs;
  logic              is_nl;
  logic              idx_ok;
  logic              cnt_last;
  logic              mem_we;
  logic [CELL_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [CELL_W-1:0] mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign is_bs      = (in_i.char_code == CHAR_BACKSPACE);
  assign is_nl      = (in_i.char_code == CHAR_NEWLINE);
  assign idx_ok     = (in_i.cell_index < CELL_W'(CELL_COUNT));
  assign cnt_last   = (cnt_q == CELL_W'(CELL_COUNT - 1));

  // Memory port control: a pending scroll copy owns the write port.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_q;
    mem_wdata = BLANK_CELL;
    mem_re    = 1'b0;
    mem_raddr = cnt_q;
    if (cp_valid_q) begin
      mem_we    = 1'b1;
      mem_waddr = cp_addr_q;
      mem_wdata = mem_rdata;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_fire && in_i.cmd == CMD_PUT) begin
          if (is_bs) begin
            if (cursor_q != '0) begin
              mem_we    = 1'b1;
              mem_waddr = cursor_q - CELL_W'(1);
            end
          end else if (!is_nl) begin
            mem_we    = 1'b1;
            mem_waddr = cursor_q;
            mem_wdata = TEXT_ATTR | {{(DATA_W - CHAR_W){1'b0}}, in_i.char_code};
          end
        end else if (in_fire && in_i.cmd == CMD_READ && idx_ok) begin
          mem_re    = 1'b1;
          mem_raddr = in_i.cell_index;
        end
      end
      ST_COPY: begin
        mem_re = 1'b1;
      end
      ST_BLANK: begin
        if (!cp_valid_q) begin
          mem_we = 1'b1;
        end
      end
      ST_INIT, ST_SWEEP: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  tcw_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (ADDR_W'(mem_waddr)),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (ADDR_W'(mem_raddr)),
    .rdata_o (mem_rdata)
  );

  // Sequencer, cursor tracking and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_INIT;
      cnt_q          <= '0;
      cp_valid_q     <= 1'b0;
      cp_addr_q      <= '0;
      cursor_q       <= '0;
      line_q         <= '0;
      col_q          <= '0;
      scrolled_q     <= 1'b0;
      rd_hit_q       <= 1'b0;
      out_valid_q    <= 1'b0;
      out_cursor_q   <= '0;
      out_value_q    <= '0;
      out_scrolled_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      cp_valid_q <= (state_q == ST_COPY);
      cp_addr_q  <= cnt_q - CELL_W'(COLUMNS);

      case (state_q)
        ST_INIT: begin
          cnt_q <= cnt_q + CELL_W'(1);
          if (cnt_last) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (in_fire) begin
            scrolled_q <= 1'b0;
            rd_hit_q   <= 1'b0;
            state_q    <= ST_DONE;
            case (in_i.cmd)
              CMD_PUT: begin
                if (is_bs) begin
                  // Backspace at home leaves everything as it is.
                  if (cursor_q != '0) begin
                    cursor_q <= cursor_q - CELL_W'(1);
                    if (col_q == '0) begin
                      col_q  <= COL_W'(COLUMNS - 1);
                      line_q <= line_q - CELL_W'(COLUMNS);
                    end else begin
                      col_q <= col_q - COL_W'(1);
                    end
                  end
                end else if (is_nl && cursor_q < CELL_W'(LAST_LINE_START)) begin
                  line_q   <= line_q + CELL_W'(COLUMNS);
                  cursor_q <= line_q + CELL_W'(COLUMNS);
                  col_q    <= '0;
                end else if (is_nl || cursor_q == CELL_W'(CELL_COUNT - 1)) begin
                  // Newline on the last line or a write into the last cell scrolls.
                  cursor_q   <= CELL_W'(LAST_LINE_START);
                  line_q     <= CELL_W'(LAST_LINE_START);
                  col_q      <= '0;
                  scrolled_q <= 1'b1;
                  cnt_q      <= CELL_W'(COLUMNS);
                  state_q    <= ST_COPY;
                end else begin
                  cursor_q <= cursor_q + CELL_W'(1);
                  if (col_q == COL_W'(COLUMNS - 1)) begin
                    col_q  <= '0;
                    line_q <= line_q + CELL_W'(COLUMNS);
                  end else begin
                    col_q <= col_q + COL_W'(1);
                  end
                end
              end
              CMD_READ: begin
                rd_hit_q <= idx_ok;
              end
              CMD_CLEAR: begin
                cursor_q <= '0;
                line_q   <= '0;
                col_q    <= '0;
                cnt_q    <= '0;
                state_q  <= ST_SWEEP;
              end
              default: begin
              end
            endcase
          end
        end

        ST_COPY: begin
          cnt_q <= cnt_q + CELL_W'(1);
          if (cnt_last) begin
            cnt_q   <= CELL_W'(LAST_LINE_START);
            state_q <= ST_BLANK;
          end
        end

        ST_BLANK: begin
          // Blanking waits while the last copy write drains.
          if (!cp_valid_q) begin
            cnt_q <= cnt_q + CELL_W'(1);
            if (cnt_last) begin
              state_q <= ST_DONE;
            end
          end
        end

        ST_SWEEP: begin
          cnt_q <= cnt_q + CELL_W'(1);
          if (cnt_last) begin
            state_q <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q    <= 1'b1;
            out_cursor_q   <= cursor_q;
            out_value_q    <= rd_hit_q ? mem_rdata : '0;
            out_scrolled_q <= scrolled_q;
            state_q        <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.cursor_pos = out_cursor_q;
  assign out_o.cell_value = out_value_q;
  assign out_o.scrolled   = out_scrolled_q;

endmodule

`default_nettype wire

@@ hw/rtl/tcw_ram.sv @@
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port; read data holds when idle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
